@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL. Build with NO_ASSERTIONS defined to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ sv/dmm_pkg.sv @@
package dmm_pkg;

   localparam int DEPTH   = 64;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [ADDR_W-1:0]  LAST_IDX   = ADDR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Request from the control logic to the min/max scanner.
   typedef struct packed {
      logic                start;
      logic [ADDR_W-1:0]   front;
      logic [COUNT_W-1:0]  count;
   } scan_req_type;

   // Scanner result. The largest and smallest values are held until the next start.
   typedef struct packed {
      logic                done;
      logic signed [DATA_W-1:0] largest;
      logic signed [DATA_W-1:0] smallest;
   } scan_res_type;

endpackage

@@ sv/dmm_ram.sv @@
module dmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dmm_scan.sv @@
module dmm_scan import dmm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  scan_req_type        scan_req,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [DATA_W-1:0]   rd_data,
   output scan_res_type        scan_res
);

   // Walks the stored entries from the front, one read per cycle, and folds
   // each returned word into the running maximum and minimum.
   logic                     busy_ff, busy_in;
   logic                     pend_ff, pend_in;
   logic                     first_ff, first_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic [COUNT_W-1:0]       remain_ff, remain_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;
   logic signed [DATA_W-1:0] lo_ff, lo_in;
   logic signed [DATA_W-1:0] word;
   logic                     done;

   assign word    = $signed(rd_data);
   assign rd_en   = busy_ff && (remain_ff != '0);
   assign rd_addr = ptr_ff;
   assign done    = busy_ff && (remain_ff == '0) && !pend_ff;

   always_comb begin
      busy_in   = busy_ff;
      pend_in   = rd_en;
      first_in  = first_ff;
      ptr_in    = ptr_ff;
      remain_in = remain_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (scan_req.start) begin
         busy_in   = 1'b1;
         pend_in   = 1'b0;
         first_in  = 1'b1;
         ptr_in    = scan_req.front;
         remain_in = scan_req.count;
         hi_in     = '0;
         lo_in     = '0;
      end else begin
         if (done) begin
            busy_in = 1'b0;
         end
         if (rd_en) begin
            ptr_in    = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
            remain_in = remain_ff - 1'b1;
         end
         if (pend_ff) begin
            first_in = 1'b0;
            if (first_ff) begin
               hi_in = word;
               lo_in = word;
            end else begin
               if (word > hi_ff) begin
                  hi_in = word;
               end
               if (word < lo_ff) begin
                  lo_in = word;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         pend_ff   <= pend_in;
         remain_ff <= remain_in;
      end
      first_ff <= first_in;
      ptr_ff   <= ptr_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign scan_res.done     = done;
   assign scan_res.largest  = hi_ff;
   assign scan_res.smallest = lo_ff;

endmodule

@@ sv/deque_with_min_max.sv @@
// An accepted item updates the front pointer and entry count and writes any pushed value
// into the memory; the min/max scan then reads the held entries from the memory, one entry
// per cycle, and its result is registered onto the outputs. No new item is accepted until
// that result is loaded, so a held-off result delays the next item.
// Reset is synchronous and active high: the queue becomes empty, no result is pending,
// and the block is ready for an item once reset is low. Stored words are not cleared.
`include "assert_macros.svh"

module deque_with_min_max import dmm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_command,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_is_empty,
   output logic signed [DATA_W-1:0]  rsp_largest,
   output logic signed [DATA_W-1:0]  rsp_smallest,
   output logic [1:0]                rsp_status
);

   // The control applies the operation to the front pointer and entry count
   // at the edge where the item is accepted, writing a pushed value into the
   // memory at that same edge. The scanner then reads the held entries in
   // later cycles, so a write and a read of the same word never overlap.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        front_ff, front_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   status_type               status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_is_empty_ff;
   logic signed [DATA_W-1:0] rsp_largest_ff;
   logic signed [DATA_W-1:0] rsp_smallest_ff;
   logic [1:0]               rsp_status_ff;

   logic                     accept;
   logic                     load_rsp;
   cmd_type                  cmd;
   logic [COUNT_W:0]         back_sum;
   logic [ADDR_W-1:0]        back_slot;
   logic [ADDR_W-1:0]        front_dec;
   logic [ADDR_W-1:0]        front_inc;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   scan_req_type             scan_req;
   scan_res_type             scan_res;
   logic                     rsp_flag_ok;

   // No item is taken while reset is high, so none can be lost to it.
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   // The slot just past the back entry: front plus count, wrapped once.
   assign back_sum  = (COUNT_W + 1)'(front_ff) + (COUNT_W + 1)'(count_ff);
   assign back_slot = (back_sum >= (COUNT_W + 1)'(DEPTH))
                      ? ADDR_W'(back_sum - (COUNT_W + 1)'(DEPTH))
                      : ADDR_W'(back_sum);
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   // Operation decode. Unused command codes behave as a query.
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_DONE;
      wr_en     = 1'b0;
      wr_addr   = back_slot;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (count_ff == FULL_COUNT) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (count_ff == FULL_COUNT) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = front_dec;
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign scan_req.start = accept;
   assign scan_req.front = front_in;
   assign scan_req.count = count_in;

   // A finished result is taken into the output register when it is empty or
   // being emptied in the same cycle; otherwise the block holds in S_WAIT.
   assign load_rsp = ((state_ff == S_SCAN && scan_res.done) || state_ff == S_WAIT)
                     && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               state_in = load_rsp ? S_IDLE : S_WAIT;
            end
         end
         S_WAIT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         status_ff    <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            front_ff  <= front_in;
            count_ff  <= count_in;
            status_ff <= status_in;
         end
      end
      if (load_rsp) begin
         rsp_count_ff    <= count_ff;
         rsp_is_empty_ff <= (count_ff == '0);
         rsp_largest_ff  <= scan_res.largest;
         rsp_smallest_ff <= scan_res.smallest;
         rsp_status_ff   <= status_ff;
      end
   end

   dmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dmm_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .scan_res (scan_res)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_largest  = rsp_largest_ff;
   assign rsp_smallest = rsp_smallest_ff;
   assign rsp_status   = rsp_status_ff;

   assign rsp_flag_ok = (rsp_is_empty == (rsp_count == '0));

   // Once an item is taken, no other item is taken until its scan has run.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready, "accepted while busy")
   // The entry count never exceeds the store depth.
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "count overflow")
   // The empty flag of a shown result agrees with its count.
   `ASSERT_IMPLIES(a_empty_flag, clock, reset, rsp_valid, rsp_flag_ok, "empty flag mismatch")
   // The scanner finishes only while the control waits for it.
   `ASSERT_IMPLIES(a_done_in_scan, clock, reset, scan_res.done, state_ff == S_SCAN, "stray done")

endmodule

@@ sim/deque_with_min_max_tb.sv @@
// Testbench for the bounded deque with min/max report.
//
// The sender drives one item at a time through the request handshake. At each
// accepted item, a shadow copy of the deque inside this module applies the
// same command and works out the response the block owes. Each response
// accepted on the result channel is compared field by field with the oldest
// outstanding prediction. The run begins with a short table of directed items.
// After that, phases of random items with a shifting push/pop balance drive
// the deque from empty to full and back many times.

module deque_with_min_max_tb;
   import dmm_pkg::*;

   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 100;
   localparam int QUIET_PHASES     = 2;     // trailing phases with no idling at all
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 80;    // longer than one full 64-entry scan
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int MAX_REPORTS      = 10;

   // Command codes above the query are unused and must behave like a query.
   localparam logic [2:0] SPARE_CMD_LO  = 3'd5;
   localparam logic [2:0] SPARE_CMD_MID = 3'd6;
   localparam logic [2:0] SPARE_CMD_HI  = 3'd7;

   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

   // One response of the block, as the predictor sees it.
   typedef struct {
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic signed [DATA_W-1:0] largest;
      logic signed [DATA_W-1:0] smallest;
      status_type               status;
   } deque_view_type;

   // One directed item. When known is set, the response is typed in the table.
   // Otherwise the shadow deque supplies it.
   typedef struct {
      logic [2:0]               command;
      logic signed [DATA_W-1:0] value;
      bit                       known;
      deque_view_type           want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_command = CMD_QUERY;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;
   logic signed [DATA_W-1:0] rsp_largest;
   logic signed [DATA_W-1:0] rsp_smallest;
   logic [1:0]               rsp_status;

   // Shadow deque: a circular store with its own front pointer and fill count.
   logic signed [DATA_W-1:0] shadow_store [DEPTH];
   int                       shadow_front = 0;
   int                       shadow_count = 0;

   // Responses that have been predicted but not yet seen, oldest first.
   deque_view_type           awaited_views [$];

   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  send_gap_pct = 0;
   int  recv_gap_pct = 0;
   bit  long_hold_pending = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   always #HALF_PERIOD clock = ~clock;

   deque_with_min_max u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_count    (rsp_count),
      .rsp_is_empty (rsp_is_empty),
      .rsp_largest  (rsp_largest),
      .rsp_smallest (rsp_smallest),
      .rsp_status   (rsp_status)
   );

   // Applies one command to the shadow deque and returns the response it calls
   // for. The min/max scan covers only live entries, so a slot that was never
   // written is never read.
   function automatic deque_view_type apply_command(input logic [2:0] command,
                                                    input logic signed [DATA_W-1:0] value);
      deque_view_type           view;
      logic signed [DATA_W-1:0] entry;
      int                       k;
      view.status = ST_DONE;
      case (command)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               view.status = ST_FULL;
            end else if (command == CMD_PUSH_BACK) begin
               shadow_store[(shadow_front + shadow_count) % DEPTH] = value;
               shadow_count++;
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_store[shadow_front] = value;
               shadow_count++;
            end
         end
         CMD_POP_BACK, CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               view.status = ST_EMPTY;
            end else begin
               if (command == CMD_POP_FRONT) begin
                  shadow_front = (shadow_front + 1) % DEPTH;
               end
               shadow_count--;
            end
         end
         default: begin
            // Queries and unused codes leave the deque as it is.
         end
      endcase
      view.count    = COUNT_W'(shadow_count);
      view.is_empty = (shadow_count == 0);
      view.largest  = '0;
      view.smallest = '0;
      for (k = 0; k < shadow_count; k++) begin
         entry = shadow_store[(shadow_front + k) % DEPTH];
         if (k == 0 || entry > view.largest) begin
            view.largest = entry;
         end
         if (k == 0 || entry < view.smallest) begin
            view.smallest = entry;
         end
      end
      return view;
   endfunction

   function automatic stim_row_type make_row(input logic [2:0] command,
                                             input logic signed [DATA_W-1:0] value,
                                             input bit known, input int count,
                                             input logic is_empty,
                                             input logic signed [DATA_W-1:0] largest,
                                             input logic signed [DATA_W-1:0] smallest,
                                             input status_type status);
      stim_row_type row;
      row.command       = command;
      row.value         = value;
      row.known         = known;
      row.want.count    = COUNT_W'(count);
      row.want.is_empty = is_empty;
      row.want.largest  = largest;
      row.want.smallest = smallest;
      row.want.status   = status;
      return row;
   endfunction

   // Presents one item and holds it steady until the block takes it. At the
   // accepting edge, the shadow deque steps, and the response owed for this
   // item joins the back of the waiting list.
   task automatic send_item(input stim_row_type row);
      deque_view_type view;
      req_valid   <= 1'b1;
      req_command <= row.command;
      req_value   <= row.value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      view = apply_command(row.command, row.value);
      awaited_views.insert(awaited_views.size(), row.known ? row.want : view);
   endtask

   // Between items the sender sometimes drops valid for a random burst. It
   // fills the payload with junk so that nothing relies on a stale command.
   task automatic sender_gap();
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid   <= 1'b0;
         req_command <= 3'($urandom);
         req_value   <= $urandom;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Result side. It checks each accepted response against the oldest
   // prediction. It then decides whether it will be ready at the next edge.
   // There is one long hold-off on request, random short stalls, and
   // otherwise ready.
   always @(posedge clock) begin : result_side
      deque_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_views.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: response with no item outstanding (count=%0d status=%0d)",
                        $time, rsp_count, rsp_status);
            end
         end else begin
            want = awaited_views[0];
            awaited_views.delete(0);
            if (rsp_count !== want.count || rsp_is_empty !== want.is_empty ||
                rsp_largest !== want.largest || rsp_smallest !== want.smallest ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: expected count=%0d empty=%0b max=%0d min=%0d status=%0d",
                           $time, want.count, want.is_empty, want.largest,
                           want.smallest, want.status);
                  $display("%0t:   actual count=%0d empty=%0b max=%0d min=%0d status=%0d",
                           $time, rsp_count, rsp_is_empty, rsp_largest,
                           rsp_smallest, rsp_status);
               end
            end
         end
      end

      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_gap_pct) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog. It ends the run if no handshake completes on either channel
   // for a stretch well beyond the slowest legitimate wait. That wait is the
   // long hold-off plus one full scan and a few stall cycles.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("deque_with_min_max_tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type directed [$];
      stim_row_type row;
      int           fill_bias [RANDOM_PHASES];
      int           phase;
      int           n;
      int           pick;

      // Directed table. Rows whose response follows from a glance at the
      // deque's contents carry it typed in. The rest are left to the shadow
      // deque. The opening rows hit an empty deque: a plain query, pops that
      // must be refused, and an unused code treated as a query.
      directed.insert(directed.size(),
                      make_row(CMD_QUERY, 32'sh12345678, 1, 0, 1, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_BACK, 32'sh0, 1, 0, 1, 0, 0, ST_EMPTY));
      directed.insert(directed.size(),
                      make_row(CMD_POP_FRONT, -32'sh1, 1, 0, 1, 0, 0, ST_EMPTY));
      directed.insert(directed.size(),
                      make_row(SPARE_CMD_LO, -32'sh1, 1, 0, 1, 0, 0, ST_DONE));
      // Both extremes of the value range, then a zero between them.
      directed.insert(directed.size(), make_row(CMD_PUSH_BACK, MOST_POSITIVE, 1, 1, 0,
                                  MOST_POSITIVE, MOST_POSITIVE, ST_DONE));
      directed.insert(directed.size(), make_row(CMD_PUSH_FRONT, MOST_NEGATIVE, 1, 2, 0,
                                  MOST_POSITIVE, MOST_NEGATIVE, ST_DONE));
      directed.insert(directed.size(), make_row(CMD_PUSH_BACK, 32'sh0, 1, 3, 0,
                                  MOST_POSITIVE, MOST_NEGATIVE, ST_DONE));
      directed.insert(directed.size(),
                      make_row(SPARE_CMD_MID, MOST_NEGATIVE, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(SPARE_CMD_HI, MOST_POSITIVE, 0, 0, 0, 0, 0, ST_DONE));
      // The payload of a pop is ignored. After these two pops, only the most
      // positive value is left.
      directed.insert(directed.size(), make_row(CMD_POP_BACK, 32'shDEADBEEF, 1, 2, 0,
                                  MOST_POSITIVE, MOST_NEGATIVE, ST_DONE));
      directed.insert(directed.size(), make_row(CMD_POP_FRONT, MOST_NEGATIVE, 1, 1, 0,
                                  MOST_POSITIVE, MOST_POSITIVE, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_FRONT, 32'sh0, 1, 0, 1, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_PUSH_FRONT, -32'sh1, 1, 1, 0, -32'sh1, -32'sh1, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_PUSH_FRONT, 32'sh1, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_PUSH_BACK, -32'sh5, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_PUSH_BACK, 32'sh1, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_QUERY, 32'shFFFF0000, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_BACK, 32'sh0, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_FRONT, 32'sh0, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_BACK, 32'sh0, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_FRONT, 32'sh0, 0, 0, 0, 0, 0, ST_DONE));
      directed.insert(directed.size(),
                      make_row(CMD_POP_BACK, 32'sh7, 1, 0, 1, 0, 0, ST_EMPTY));

      // Share of pushes per random phase. The strongly push-heavy phases run
      // the deque into full, so that refused pushes show up. The pop-heavy
      // phases drain it and exercise pops on an empty deque again.
      fill_bias = '{90, 15, 60, 85, 50, 10, 95, 40, 70, 20, 55, 50};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 15;
      recv_gap_pct = 15;
      foreach (directed[i]) begin
         send_item(directed[i]);
         sender_gap();
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Idling on each side changes from phase to phase, so stretches in which one
         // side has no gaps alternate with heavy stalling. The final phases run
         // with no idling on either side.
         if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end else begin
            send_gap_pct = (phase % 3 == 0) ? 20 : (phase % 3 == 1) ? 0 : 45;
            recv_gap_pct = (phase % 3 == 1) ? 20 : (phase % 3 == 2) ? 0 : 45;
         end

         // The result side stops for a long stretch. The sender keeps
         // offering items, so the block has to hold its result and stall
         // its input.
         if (phase == 3) begin
            long_hold_pending = 1'b1;
         end

         // The sender goes silent until every outstanding response has
         // arrived.
         if (phase == 6) begin
            while (awaited_views.size() != 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
         end

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               row.command = 3'($urandom_range(CMD_QUERY, SPARE_CMD_HI));
            end else if (pick < 6 + (fill_bias[phase] * 94) / 100) begin
               row.command = 3'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT));
            end else begin
               row.command = 3'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT));
            end
            // Extremes and a narrow band of small values give frequent ties
            // and frequent changes of the min and max. Full-range values
            // cover every bit.
            case ($urandom_range(0, 5))
               0:       row.value = MOST_POSITIVE;
               1:       row.value = MOST_NEGATIVE;
               2, 3:    row.value = DATA_W'($urandom_range(0, 16)) - 32'sd8;
               default: row.value = $urandom;
            endcase
            row.known = 1'b0;
            send_item(row);
            sender_gap();
         end
      end
      req_valid <= 1'b0;

      // Wait for every prediction to be matched. Then leave room for a
      // response that should not exist, which would be flagged as unexpected.
      while (awaited_views.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("deque_with_min_max_tb: done, clean");
      end else begin
         $display("deque_with_min_max_tb: done, errors");
      end
      $finish;
   end

endmodule
